// ===== hdl/pfe_pkg.sv =====
// Playfair digram encrypt: shared types, constants and helper functions.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package pfe_pkg;

	localparam int LETTER_W = 5;
	localparam int LETTERS  = 26;
	localparam int CELLS    = 25;
	localparam int SIDE     = 5;
	localparam int RC_W     = 3;
	localparam int KEY_W    = 60;
	localparam int LEN_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_KEY_LETTERS_DEF = 12;

	localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
	localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

	// key MONARCHY, length 8
	localparam logic [KEY_W-1:0] RESET_KEY = 60'd832234862028;
	localparam logic [LEN_W-1:0] RESET_LEN = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LETTERS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [4:0] cell_t;

	typedef struct packed {
		logic [RC_W-1:0] row;
		logic [RC_W-1:0] col;
	} rc_t;

	typedef struct packed {
		letter_t plain_first;
		letter_t plain_second;
	} plain_t;

	typedef struct packed {
		letter_t cipher_first;
		letter_t cipher_second;
	} cipher_t;

	// one table update from the square builder
	typedef struct packed {
		logic    en;
		letter_t letter;
		cell_t   pos;
	} wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_KEY,
		ST_FILL
	} build_st_t;

	function automatic cell_t rc_cell(input rc_t rc);
		cell_t base;
		begin
			base = cell_t'({rc.row, 2'b00}) + cell_t'(rc.row);
			rc_cell = base + cell_t'(rc.col);
		end
	endfunction

	// cell index to row and column without a divider
	function automatic rc_t cell_rc(input cell_t pos);
		rc_t   rc;
		cell_t base;
		begin
			if (pos >= 5'd20) begin
				rc.row = 3'd4;
			end else if (pos >= 5'd15) begin
				rc.row = 3'd3;
			end else if (pos >= 5'd10) begin
				rc.row = 3'd2;
			end else if (pos >= 5'd5) begin
				rc.row = 3'd1;
			end else begin
				rc.row = 3'd0;
			end
			base = cell_t'({rc.row, 2'b00}) + cell_t'(rc.row);
			rc.col = RC_W'(pos - base);
			cell_rc = rc;
		end
	endfunction

endpackage

// ===== hdl/pfe_builder.sv =====
// Key square builder: holds the key registers and walks key letters, then the
// alphabet, one letter a cycle, issuing table writes. Depends on pfe_pkg.
`timescale 1ns / 1ps

module pfe_builder #(
	parameter int MAX_KEY_LETTERS = pfe_pkg::MAX_KEY_LETTERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [pfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfe_pkg::KEY_W-1:0]        cfg_data,
	output pfe_pkg::wr_t                     wr,
	output logic                             building
);

	localparam int SH_W = MAX_KEY_LETTERS * pfe_pkg::LETTER_W;
	localparam logic [4:0] KEY_LAST  = 5'(MAX_KEY_LETTERS - 1);
	localparam logic [4:0] FILL_LAST = 5'(pfe_pkg::LETTERS - 1);
	localparam logic [pfe_pkg::LEN_W-1:0] MAX_LEN = pfe_pkg::LEN_W'(MAX_KEY_LETTERS);
	// J never enters the square
	localparam logic [pfe_pkg::LETTERS-1:0] TAKEN_INIT =
		pfe_pkg::LETTERS'(1) << pfe_pkg::LETTER_J;

	pfe_pkg::build_st_t state_q, state_nx;

	logic [pfe_pkg::KEY_W-1:0]   key_q;
	logic [pfe_pkg::LEN_W-1:0]   len_q;
	logic [SH_W-1:0]             key_sh_q;
	logic [4:0]                  step_q;
	logic [4:0]                  fill_q;
	logic [pfe_pkg::LETTERS-1:0] taken_q;

	logic                        cfg_hit;
	logic [pfe_pkg::LEN_W-1:0]   count;
	pfe_pkg::letter_t            cand;
	logic                        cand_free;

	assign cfg_hit = cfg_write &&
		(cfg_index == pfe_pkg::CFG_KEY_LETTERS || cfg_index == pfe_pkg::CFG_KEY_LENGTH);
	assign count = (len_q > MAX_LEN) ? MAX_LEN : len_q;
	assign building = (state_q != pfe_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfe_pkg::ST_START;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cand = pfe_pkg::letter_t'(step_q);
		cand_free = 1'b0;
		wr = '0;
		unique case (state_q)
			pfe_pkg::ST_IDLE: begin
			end
			pfe_pkg::ST_START: begin
				state_nx = pfe_pkg::ST_KEY;
			end
			pfe_pkg::ST_KEY: begin
				cand = key_sh_q[pfe_pkg::LETTER_W-1:0];
				// codes above Z are skipped like J
				cand_free = (cand < pfe_pkg::LETTER_W'(pfe_pkg::LETTERS)) ?
					!taken_q[cand] : 1'b0;
				wr.en = cand_free && (step_q < 5'(count)) &&
					(fill_q < 5'(pfe_pkg::CELLS));
				if (step_q == KEY_LAST) begin
					state_nx = pfe_pkg::ST_FILL;
				end
			end
			pfe_pkg::ST_FILL: begin
				cand_free = !taken_q[cand];
				wr.en = cand_free && (fill_q < 5'(pfe_pkg::CELLS));
				if (step_q == FILL_LAST) begin
					state_nx = pfe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = pfe_pkg::ST_START;
			end
		endcase
		wr.letter = cand;
		wr.pos = fill_q;
		// any key write restarts the build
		if (cfg_hit) begin
			state_nx = pfe_pkg::ST_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= pfe_pkg::RESET_KEY;
			len_q <= pfe_pkg::RESET_LEN;
			key_sh_q <= '0;
			step_q <= '0;
			fill_q <= '0;
			taken_q <= '0;
		end else begin
			if (cfg_write && cfg_index == pfe_pkg::CFG_KEY_LETTERS) begin
				key_q <= cfg_data;
			end
			if (cfg_write && cfg_index == pfe_pkg::CFG_KEY_LENGTH) begin
				len_q <= cfg_data[pfe_pkg::LEN_W-1:0];
			end
			if (state_q == pfe_pkg::ST_START) begin
				key_sh_q <= key_q[SH_W-1:0];
				step_q <= '0;
				fill_q <= '0;
				taken_q <= TAKEN_INIT;
			end else if (state_q == pfe_pkg::ST_KEY || state_q == pfe_pkg::ST_FILL) begin
				key_sh_q <= key_sh_q >> pfe_pkg::LETTER_W;
				step_q <= (state_q == pfe_pkg::ST_KEY && step_q == KEY_LAST) ? '0 : step_q + 5'd1;
				if (wr.en) begin
					taken_q[wr.letter] <= 1'b1;
					fill_q <= fill_q + 5'd1;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 5'(pfe_pkg::CELLS))
		else $error("square fill count past 25 cells");

	a_fill_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfe_pkg::ST_FILL && step_q == FILL_LAST && !cfg_hit)
		|=> fill_q == 5'(pfe_pkg::CELLS))
		else $error("square build ended with empty cells");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!building |-> !wr.en)
		else $error("table write outside a build");
`endif

endmodule

// ===== hdl/pfe_lane.sv =====
// One letter lane: folds J and out-of-range codes, looks up the letter's cell
// in its own copy of the position table, splits it into row and column. pfe_pkg.
`timescale 1ns / 1ps

module pfe_lane (
	input  logic              clk,
	input  logic              accept,
	input  pfe_pkg::letter_t  letter,
	input  pfe_pkg::wr_t      wr,
	output pfe_pkg::rc_t      rc
);

	pfe_pkg::cell_t   pos_mem [pfe_pkg::LETTERS];
	pfe_pkg::cell_t   pos_s1;
	pfe_pkg::letter_t addr;

	always_comb begin
		addr = letter;
		if (letter > pfe_pkg::LETTER_Z) begin
			addr = pfe_pkg::LETTER_Z;
		end else if (letter == pfe_pkg::LETTER_J) begin
			addr = pfe_pkg::LETTER_I;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			pos_mem[wr.letter] <= wr.pos;
		end
		if (accept) begin
			pos_s1 <= pos_mem[addr];
		end
	end

	assign rc = pfe_pkg::cell_rc(pos_s1);

endmodule

// ===== hdl/pfe_merge.sv =====
// Merge stage: applies the row, column and rectangle rules to both lanes'
// coordinates and reads the key square at the two result cells. pfe_pkg.
`timescale 1ns / 1ps

module pfe_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  pfe_pkg::rc_t     rc_first,
	input  pfe_pkg::rc_t     rc_second,
	input  pfe_pkg::wr_t     wr,
	output logic             valid_s2,
	output pfe_pkg::cipher_t cipher_s2
);

	localparam logic [pfe_pkg::RC_W-1:0] EDGE_RC = pfe_pkg::RC_W'(pfe_pkg::SIDE - 1);

	pfe_pkg::letter_t sq_mem [pfe_pkg::CELLS];
	pfe_pkg::rc_t     out_first, out_second;
	pfe_pkg::cell_t   cell_first, cell_second;

	function automatic logic [pfe_pkg::RC_W-1:0] wrap_inc(input logic [pfe_pkg::RC_W-1:0] v);
		wrap_inc = (v == EDGE_RC) ? '0 : v + 3'd1;
	endfunction

	always_comb begin
		out_first = rc_first;
		out_second = rc_second;
		priority if (rc_first.row == rc_second.row) begin
			// also covers a doubled letter
			out_first.col = wrap_inc(rc_first.col);
			out_second.col = wrap_inc(rc_second.col);
		end else if (rc_first.col == rc_second.col) begin
			out_first.row = wrap_inc(rc_first.row);
			out_second.row = wrap_inc(rc_second.row);
		end else begin
			out_first.col = rc_second.col;
			out_second.col = rc_first.col;
		end
		cell_first = pfe_pkg::rc_cell(out_first);
		cell_second = pfe_pkg::rc_cell(out_second);
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			sq_mem[wr.pos] <= wr.letter;
		end
		if (valid_s1) begin
			cipher_s2.cipher_first <= sq_mem[cell_first];
			cipher_s2.cipher_second <= sq_mem[cell_second];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

endmodule

// ===== hdl/playfair_digram_encrypt_core.sv =====
// Playfair digram encrypt top level: key square builder, two letter lanes and
// the merge stage. Depends on pfe_pkg, pfe_builder, pfe_lane, pfe_merge.
`timescale 1ns / 1ps

// One plaintext pair is taken per cycle whenever start is high and busy is low;
// its ciphertext pair appears on cipher_pair with done high for one cycle, after
// the registered position lookup in each lane and the registered key square read
// in the merge stage, and must be captured then since the receiver cannot stall
// the block. After reset and after every key write, busy stays high while the
// builder walks the key letters and then the alphabet, writing a table entry for
// each letter not yet placed.
module playfair_digram_encrypt_core #(
	parameter int MAX_KEY_LETTERS = pfe_pkg::MAX_KEY_LETTERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [pfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfe_pkg::KEY_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  pfe_pkg::plain_t               plain_pair,
	output logic                          done,
	output pfe_pkg::cipher_t              cipher_pair
);

	logic         accept;
	logic         valid_s1;
	pfe_pkg::wr_t wr;
	pfe_pkg::rc_t rc_first, rc_second;

	assign accept = start && !busy;

	pfe_builder #(
		.MAX_KEY_LETTERS(MAX_KEY_LETTERS)
	) u_builder (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr        (wr),
		.building  (busy)
	);

	pfe_lane u_lane_first (
		.clk    (clk),
		.accept (accept),
		.letter (plain_pair.plain_first),
		.wr     (wr),
		.rc     (rc_first)
	);

	pfe_lane u_lane_second (
		.clk    (clk),
		.accept (accept),
		.letter (plain_pair.plain_second),
		.wr     (wr),
		.rc     (rc_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	pfe_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.rc_first  (rc_first),
		.rc_second (rc_second),
		.wr        (wr),
		.valid_s2  (done),
		.cipher_s2 (cipher_pair)
	);

`ifndef ASSERT_OFF
	a_done_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result strobe without an item two cycles before");

	a_no_j_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cipher_pair.cipher_first != pfe_pkg::LETTER_J &&
			cipher_pair.cipher_second != pfe_pkg::LETTER_J))
		else $error("ciphertext letter J");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cipher_pair.cipher_first <= pfe_pkg::LETTER_Z &&
			cipher_pair.cipher_second <= pfe_pkg::LETTER_Z))
		else $error("ciphertext letter beyond Z");
`endif

endmodule

// ===== tb/tb_playfair_digram_encrypt_core.sv =====
// Self-checking testbench for playfair_digram_encrypt_core: predicts each cipher pair
// from its own copy of the key square and checks every item the block returns.
// Depends on pfe_pkg and the RTL of playfair_digram_encrypt_core.
`timescale 1ns / 1ps

module tb_playfair_digram_encrypt_core;

	import pfe_pkg::*;

	// register indexes that select no register
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam int RANDOM_ITEMS_PER_SETTING = 100;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KEY_W-1:0]     cfg_data = '0;
	logic                 start = 1'b0;
	logic                 busy;
	plain_t               plain_pair = '0;
	logic                 done;
	cipher_t              cipher_pair;

	plain_t  plain_queue[$];
	cipher_t cipher_expected[$];
	int      idle_pct = 0;
	int      error_count = 0;

	// predictor copy of the registers and the tables
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] key_len_q;
	letter_t          square_q[CELLS];
	int               letter_pos_q[LETTERS];

	playfair_digram_encrypt_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.plain_pair (plain_pair),
		.done       (done),
		.cipher_pair(cipher_pair)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic rebuild_square();
		logic    used[LETTERS];
		int      fill;
		int      count;
		int      k;
		letter_t c;
		count = int'(key_len_q);
		if (count > MAX_KEY_LETTERS_DEF) count = MAX_KEY_LETTERS_DEF;
		for (k = 0; k < LETTERS; k++) used[k] = 1'b0;
		used[LETTER_J] = 1'b1;
		fill = 0;
		// key letters first; J, repeats and codes past Z are skipped
		for (k = 0; k < count; k++) begin
			c = key_q[5*k +: 5];
			if (int'(c) < LETTERS && fill < CELLS) begin
				if (!used[c]) begin
					used[c] = 1'b1;
					square_q[fill] = c;
					letter_pos_q[c] = fill;
					fill++;
				end
			end
		end
		for (k = 0; k < LETTERS; k++) begin
			if (!used[k] && fill < CELLS) begin
				used[k] = 1'b1;
				square_q[fill] = letter_t'(k);
				letter_pos_q[k] = fill;
				fill++;
			end
		end
		letter_pos_q[LETTER_J] = letter_pos_q[LETTER_I];
	endtask

	function automatic int letter_cell(letter_t l);
		letter_t c;
		c = l;
		if (int'(c) >= LETTERS) c = LETTER_Z;
		if (c == LETTER_J) c = LETTER_I;
		return letter_pos_q[c];
	endfunction

	function automatic cipher_t encrypt_pair(plain_t p);
		int      p1, p2, r1, c1, r2, c2, o1, o2;
		cipher_t r;
		p1 = letter_cell(p.plain_first);
		p2 = letter_cell(p.plain_second);
		r1 = p1 / SIDE;
		c1 = p1 % SIDE;
		r2 = p2 / SIDE;
		c2 = p2 % SIDE;
		if (r1 == r2) begin
			// also covers a doubled letter
			o1 = r1 * SIDE + (c1 + 1) % SIDE;
			o2 = r2 * SIDE + (c2 + 1) % SIDE;
		end else if (c1 == c2) begin
			o1 = ((r1 + 1) % SIDE) * SIDE + c1;
			o2 = ((r2 + 1) % SIDE) * SIDE + c2;
		end else begin
			o1 = r1 * SIDE + c2;
			o2 = r2 * SIDE + c1;
		end
		r.cipher_first = square_q[o1];
		r.cipher_second = square_q[o2];
		return r;
	endfunction

	// driver: one item per accept, random idle cycles between items
	always @(posedge clk or negedge arst_n) begin : drive_proc
		if (!arst_n) begin
			start <= 1'b0;
			plain_pair <= '0;
		end else if (!start || !busy) begin
			if (plain_queue.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
				start <= 1'b1;
				plain_pair <= plain_queue.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: tracks register writes, predicts accepted items, checks results
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		cipher_t exp_c;
		if (!arst_n) begin
			key_q = RESET_KEY;
			key_len_q = RESET_LEN;
			rebuild_square();
		end else begin
			if (done) begin
				if (cipher_expected.size() == 0) begin
					$error("unexpected item: cipher_first=%0d cipher_second=%0d",
						cipher_pair.cipher_first, cipher_pair.cipher_second);
					error_count++;
				end else begin
					exp_c = cipher_expected.pop_front();
					if (cipher_pair.cipher_first !== exp_c.cipher_first) begin
						$error("cipher_first: expected %0d, actual %0d",
							exp_c.cipher_first, cipher_pair.cipher_first);
						error_count++;
					end
					if (cipher_pair.cipher_second !== exp_c.cipher_second) begin
						$error("cipher_second: expected %0d, actual %0d",
							exp_c.cipher_second, cipher_pair.cipher_second);
						error_count++;
					end
				end
			end
			if (start && !busy) cipher_expected.push_back(encrypt_pair(plain_pair));
			if (cfg_write) begin
				if (cfg_index == CFG_KEY_LETTERS) begin
					key_q = cfg_data;
					rebuild_square();
				end else if (cfg_index == CFG_KEY_LENGTH) begin
					key_len_q = cfg_data[LEN_W-1:0];
					rebuild_square();
				end
			end
		end
	end

	task automatic wait_ready();
		@(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		// the rebuild raises busy after the write lands
		repeat (2) @(posedge clk);
		wait_ready();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (plain_queue.size() != 0 || start || cipher_expected.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic letter_t rand_letter();
		if ($urandom_range(7, 0) == 0) return letter_t'($urandom_range(31, 26));
		return letter_t'($urandom_range(25, 0));
	endfunction

	task automatic push_random(int n);
		plain_t p;
		for (int i = 0; i < n; i++) begin
			p.plain_first = rand_letter();
			p.plain_second = ($urandom_range(7, 0) == 0) ? p.plain_first : rand_letter();
			plain_queue.push_back(p);
		end
	endtask

	task automatic push_pair(int a, int b);
		plain_t p;
		p.plain_first = letter_t'(a);
		p.plain_second = letter_t'(b);
		plain_queue.push_back(p);
	endtask

	// key of twelve letters with J, codes past Z and repeats mixed in
	function automatic logic [KEY_W-1:0] rough_key();
		logic [KEY_W-1:0] k;
		k = '0;
		for (int i = 0; i < MAX_KEY_LETTERS_DEF; i++) begin
			case ($urandom_range(3, 0))
				0: k[5*i +: 5] = LETTER_J;
				1: k[5*i +: 5] = letter_t'($urandom_range(31, 26));
				2: k[5*i +: 5] = k[5*$urandom_range(i, 0) +: 5];
				default: k[5*i +: 5] = letter_t'($urandom_range(25, 0));
			endcase
		end
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] clean_key();
		logic [KEY_W-1:0] k;
		for (int i = 0; i < MAX_KEY_LETTERS_DEF; i++)
			k[5*i +: 5] = letter_t'($urandom_range(25, 0));
		return k;
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		wait_ready();

		// reset key: doubled letters, J against I, codes past Z, wraps and rectangles
		idle_pct = 36;
		push_pair(0, 0);
		push_pair(25, 25);
		push_pair(9, 8);
		push_pair(8, 9);
		push_pair(9, 9);
		push_pair(31, 31);
		push_pair(26, 0);
		push_pair(0, 30);
		push_pair(12, 17);
		push_pair(17, 12);
		push_pair(17, 25);
		push_pair(25, 17);
		push_pair(12, 25);
		push_pair(0, 23);
		push_pair(7, 24);
		push_pair(24, 7);
		push_pair(25, 0);
		push_pair(0, 25);
		push_pair(16, 1);
		push_pair(20, 25);
		push_pair(9, 25);
		push_pair(27, 9);
		push_random(RANDOM_ITEMS_PER_SETTING);
		wait_drained();

		// all ones: every key code skipped, length past the maximum
		write_reg(CFG_KEY_LETTERS, '1);
		write_reg(CFG_KEY_LENGTH, '1);
		write_reg(CFG_SPARE_2, KEY_W'({$urandom, $urandom}));
		write_reg(CFG_SPARE_3, KEY_W'({$urandom, $urandom}));
		push_random(RANDOM_ITEMS_PER_SETTING);
		wait_drained();

		// empty key
		idle_pct = 48;
		write_reg(CFG_KEY_LETTERS, KEY_W'({$urandom, $urandom}));
		write_reg(CFG_KEY_LENGTH, '0);
		push_random(RANDOM_ITEMS_PER_SETTING);
		wait_drained();

		write_reg(CFG_KEY_LETTERS, rough_key());
		write_reg(CFG_KEY_LENGTH, KEY_W'({$urandom, 4'(MAX_KEY_LETTERS_DEF)}));
		push_random(RANDOM_ITEMS_PER_SETTING);
		wait_drained();

		idle_pct = 0;
		write_reg(CFG_KEY_LETTERS, rough_key());
		write_reg(CFG_KEY_LENGTH, KEY_W'({$urandom, 4'($urandom_range(11, 1))}));
		push_random(RANDOM_ITEMS_PER_SETTING);
		wait_drained();

		write_reg(CFG_KEY_LENGTH, KEY_W'(MAX_KEY_LETTERS_DEF));
		write_reg(CFG_KEY_LETTERS, clean_key());
		push_random(RANDOM_ITEMS_PER_SETTING);
		wait_drained();

		if (error_count == 0) begin
			$display("playfair_digram_encrypt_core test passed");
		end else begin
			$display("playfair_digram_encrypt_core test failed");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("playfair_digram_encrypt_core test failed");
		$finish;
	end

endmodule
